/* hw/rtl/brr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_pkg
// Shared constants for the box regression refine block: default widths,
// fixed field widths, pipeline depth, register indexes and register reset values.
// ----------------------------------------------------------------------------
package brr_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF = 14;
  localparam int FRAC_BITS_DEF  = 14;

  // fixed field widths
  localparam int OFFS_BITS    = 16;  // regression offsets, signed fixed point
  localparam int DIM_BITS     = 13;  // image width / height registers
  localparam int SCALE_BITS   = 16;  // square height ratio, unsigned Q4.12
  localparam int SCALE_FRAC   = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DAT_BITS = 16;

  // pipeline depth, output register included
  localparam int NUM_STAGES = 10;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SQUARE_MODE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_SCALE   = 2'd3;

  // register reset values
  localparam logic [DIM_BITS-1:0]   IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [DIM_BITS-1:0]   IMAGE_HEIGHT_RST = 13'd480;
  localparam logic                  SQUARE_MODE_RST  = 1'b1;
  localparam logic [SCALE_BITS-1:0] SIDE_SCALE_RST   = 16'd4096;

endpackage

/* hw/rtl/brr_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr channel interfaces
// Valid/ready channels of the block: candidate box in, refined box out and
// the register write channel.
// ----------------------------------------------------------------------------

interface brr_in_if #(
  parameter int COORD_BITS = brr_pkg::COORD_BITS_DEF
);
  import brr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_left;
  logic signed [COORD_BITS-1:0] box_top;
  logic signed [COORD_BITS-1:0] box_right;
  logic signed [COORD_BITS-1:0] box_bottom;
  logic signed [COORD_BITS-1:0] box_width;
  logic signed [COORD_BITS-1:0] box_height;
  logic signed [OFFS_BITS-1:0]  offset_left;
  logic signed [OFFS_BITS-1:0]  offset_top;
  logic signed [OFFS_BITS-1:0]  offset_right;
  logic signed [OFFS_BITS-1:0]  offset_bottom;

  modport source (
    output valid, box_left, box_top, box_right, box_bottom, box_width, box_height,
           offset_left, offset_top, offset_right, offset_bottom,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_right, box_bottom, box_width, box_height,
           offset_left, offset_top, offset_right, offset_bottom,
    output ready
  );
endinterface

interface brr_out_if #(
  parameter int COORD_BITS = brr_pkg::COORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS-1:0] out_left;
  logic signed [COORD_BITS-1:0] out_top;
  logic signed [COORD_BITS-1:0] out_right;
  logic signed [COORD_BITS-1:0] out_bottom;
  logic signed [COORD_BITS:0]   out_width;
  logic signed [COORD_BITS:0]   out_height;

  modport source (
    output valid, out_left, out_top, out_right, out_bottom, out_width, out_height,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_right, out_bottom, out_width, out_height,
    output ready
  );
endinterface

interface brr_cfg_if;
  import brr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] addr;
  logic [CFG_DAT_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* hw/rtl/brr_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_round
// Divides a signed value by 2^SHIFT, rounding half away from zero. The
// result is one bit wider than the quotient magnitude so it never wraps.
// ----------------------------------------------------------------------------
module brr_round #(
  parameter int IN_W  = 32,
  parameter int SHIFT = 1
) (
  input  logic signed [IN_W-1:0]     val_i,
  output logic signed [IN_W-SHIFT:0] res_o
);
  localparam int OW = IN_W - SHIFT + 1;
  localparam logic [IN_W:0] HALF = (IN_W + 1)'(1) << (SHIFT - 1);

  logic          neg;
  logic [IN_W:0] mag;
  logic [IN_W:0] mag_half;
  logic [OW-1:0] quot;

  // magnitude, add half, truncate, restore sign
  assign neg      = val_i[IN_W-1];
  assign mag      = neg ? -(IN_W + 1)'(val_i) : (IN_W + 1)'(val_i);
  assign mag_half = mag + HALF;
  assign quot     = OW'(mag_half >> SHIFT);
  assign res_o    = neg ? -$signed(quot) : $signed(quot);

endmodule

/* hw/rtl/box_regression_refine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_regression_refine
// Moves each corner of a candidate box by its regression offset scaled by the
// box size, optionally squares the box about its centre, rounds the corners,
// clamps them to the image and reports the refined width and height.
// ----------------------------------------------------------------------------
//  channel | dir | modport | beat
//  cfg_ch  | in  | sink    | register index and write data
//  in_ch   | in  | sink    | candidate box: corners, size, four offsets
//  out_ch  | out | source  | refined corners, width and height
//
//  One box per cycle sustained while out_ch does not stall; each box passes
//  through the ten register stages of the pipe before its result shows on out_ch.
//  Reset clears every stage valid bit and restores the register defaults.
//  A stall on out_ch holds only the stages that are full: empty stages keep
//  filling, so bubbles close up and no beat is lost or repeated.
// ----------------------------------------------------------------------------
module box_regression_refine #(
  parameter int COORD_BITS = brr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = brr_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brr_cfg_if.sink    cfg_ch,
  brr_in_if.sink     in_ch,
  brr_out_if.source  out_ch
);
  import brr_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NS  = NUM_STAGES;
  localparam int PW  = OFFS_BITS + C;                      // offset * size
  localparam int E   = ((C + F) > PW ? (C + F) : PW) + 1;  // moved edge
  localparam int WW  = E + 2;                              // w, h, side
  localparam int MP  = WW + SCALE_BITS + 1;                // side * scale
  localparam int HW  = MP - SCALE_FRAC + 1;                // rounded hside
  localparam int DW  = HW + 3;                             // doubled corners
  localparam int RW  = DW - F;                             // rounded corners
  localparam int CW  = (C > DIM_BITS ? C : DIM_BITS) + 2;  // clamp compare

  localparam logic signed [WW-1:0] ONE_W   = WW'(1) << F;
  localparam logic signed [DW-1:0] TWO_ONE = DW'(2) << F;
  localparam logic signed [RW-1:0] SAT_HI  = RW'((1 << (C - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO  = -RW'(1 << (C - 1));

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_BITS-1:0]   img_w_q;
  logic [DIM_BITS-1:0]   img_h_q;
  logic                  square_q;
  logic [SCALE_BITS-1:0] scale_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= IMAGE_WIDTH_RST;
      img_h_q  <= IMAGE_HEIGHT_RST;
      square_q <= SQUARE_MODE_RST;
      scale_q  <= SIDE_SCALE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_IMAGE_WIDTH:  img_w_q  <= cfg_ch.data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: img_h_q  <= cfg_ch.data[DIM_BITS-1:0];
        CFG_SQUARE_MODE:  square_q <= cfg_ch.data[0];
        CFG_SIDE_SCALE:   scale_q  <= cfg_ch.data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when empty or when the next one moves
  // --------------------------------------------------------------------------
  logic [NS-1:0] valid_q;
  logic [NS-1:0] stage_en;

  always_comb begin
    stage_en[NS-1] = ~valid_q[NS-1] | out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_en[k] = ~valid_q[k] | stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) valid_q[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (stage_en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_ch.ready = stage_en[0];

  // --------------------------------------------------------------------------
  // stage 1: offset times box size
  // --------------------------------------------------------------------------
  logic signed [C-1:0]  s1_l_q, s1_t_q, s1_r_q, s1_b_q;
  logic signed [PW-1:0] s1_pl_q, s1_pt_q, s1_pr_q, s1_pb_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s1_l_q  <= in_ch.box_left;
      s1_t_q  <= in_ch.box_top;
      s1_r_q  <= in_ch.box_right;
      s1_b_q  <= in_ch.box_bottom;
      s1_pl_q <= PW'(in_ch.offset_left)   * PW'(in_ch.box_width);
      s1_pt_q <= PW'(in_ch.offset_top)    * PW'(in_ch.box_height);
      s1_pr_q <= PW'(in_ch.offset_right)  * PW'(in_ch.box_width);
      s1_pb_q <= PW'(in_ch.offset_bottom) * PW'(in_ch.box_height);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: moved edges in fixed point
  // --------------------------------------------------------------------------
  logic signed [E-1:0] s2_x0_q, s2_y0_q, s2_x1_q, s2_y1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s2_x0_q <= (E'(s1_l_q) <<< F) + E'(s1_pl_q);
      s2_y0_q <= (E'(s1_t_q) <<< F) + E'(s1_pt_q);
      s2_x1_q <= (E'(s1_r_q) <<< F) + E'(s1_pr_q);
      s2_y1_q <= (E'(s1_b_q) <<< F) + E'(s1_pb_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: box size and longer side
  // --------------------------------------------------------------------------
  logic signed [WW-1:0] s3_w, s3_h;
  logic signed [WW-1:0] s3_w_q, s3_h_q, s3_side_q;
  logic signed [E-1:0]  s3_x0_q, s3_y0_q, s3_x1_q, s3_y1_q;

  assign s3_w = WW'(s2_x1_q) - WW'(s2_x0_q) + ONE_W;
  assign s3_h = WW'(s2_y1_q) - WW'(s2_y0_q) + ONE_W;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      s3_w_q    <= s3_w;
      s3_h_q    <= s3_h;
      s3_side_q <= (s3_h > s3_w) ? s3_h : s3_w;
      s3_x0_q   <= s2_x0_q;
      s3_y0_q   <= s2_y0_q;
      s3_x1_q   <= s2_x1_q;
      s3_y1_q   <= s2_y1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: scaled height product, centred square left edge
  // --------------------------------------------------------------------------
  logic signed [MP-1:0] s4_prod_q;
  logic signed [DW-1:0] s4_dx0_q;
  logic signed [WW-1:0] s4_side_q, s4_h_q;
  logic signed [E-1:0]  s4_y0_q, s4_x0_q, s4_x1_q, s4_y1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      s4_prod_q <= MP'(s3_side_q) * MP'($signed({1'b0, scale_q}));
      s4_dx0_q  <= (DW'(s3_x0_q) <<< 1) + DW'(s3_w_q) - DW'(s3_side_q);
      s4_side_q <= s3_side_q;
      s4_h_q    <= s3_h_q;
      s4_x0_q   <= s3_x0_q;
      s4_y0_q   <= s3_y0_q;
      s4_x1_q   <= s3_x1_q;
      s4_y1_q   <= s3_y1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: round scaled height, square right edge
  // --------------------------------------------------------------------------
  logic signed [HW-1:0] s5_hside;
  logic signed [HW-1:0] s5_hside_q;
  logic signed [DW-1:0] s5_dx0_q, s5_dx1_q;
  logic signed [WW-1:0] s5_h_q;
  logic signed [E-1:0]  s5_y0_q, s5_x0_q, s5_x1_q, s5_y1_q;

  brr_round #(
    .IN_W  (MP),
    .SHIFT (SCALE_FRAC)
  ) u_round_hside (
    .val_i (s4_prod_q),
    .res_o (s5_hside)
  );

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      s5_hside_q <= s5_hside;
      s5_dx0_q   <= s4_dx0_q;
      s5_dx1_q   <= s4_dx0_q + (DW'(s4_side_q) <<< 1) - TWO_ONE;
      s5_h_q     <= s4_h_q;
      s5_x0_q    <= s4_x0_q;
      s5_y0_q    <= s4_y0_q;
      s5_x1_q    <= s4_x1_q;
      s5_y1_q    <= s4_y1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: square top edge, x corners chosen by mode
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s6_dy0_q, s6_fx0_q, s6_fx1_q;
  logic signed [HW-1:0] s6_hside_q;
  logic signed [E-1:0]  s6_y0_q, s6_y1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      s6_dy0_q   <= (DW'(s5_y0_q) <<< 1) + DW'(s5_h_q) - DW'(s5_hside_q);
      s6_fx0_q   <= square_q ? s5_dx0_q : (DW'(s5_x0_q) <<< 1);
      s6_fx1_q   <= square_q ? s5_dx1_q : (DW'(s5_x1_q) <<< 1);
      s6_hside_q <= s5_hside_q;
      s6_y0_q    <= s5_y0_q;
      s6_y1_q    <= s5_y1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: square bottom edge, y corners chosen by mode
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s7_fx0_q, s7_fx1_q, s7_fy0_q, s7_fy1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      s7_fx0_q <= s6_fx0_q;
      s7_fx1_q <= s6_fx1_q;
      s7_fy0_q <= square_q ? s6_dy0_q : (DW'(s6_y0_q) <<< 1);
      s7_fy1_q <= square_q ? (s6_dy0_q + (DW'(s6_hside_q) <<< 1) - TWO_ONE)
                           : (DW'(s6_y1_q) <<< 1);
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: round corners to pixels and saturate to coordinate range
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] s8_rl, s8_rt, s8_rr, s8_rb;
  logic signed [C-1:0]  s8_l_q, s8_t_q, s8_r_q, s8_b_q;

  brr_round #(.IN_W(DW), .SHIFT(F + 1)) u_round_l (.val_i(s7_fx0_q), .res_o(s8_rl));
  brr_round #(.IN_W(DW), .SHIFT(F + 1)) u_round_t (.val_i(s7_fy0_q), .res_o(s8_rt));
  brr_round #(.IN_W(DW), .SHIFT(F + 1)) u_round_r (.val_i(s7_fx1_q), .res_o(s8_rr));
  brr_round #(.IN_W(DW), .SHIFT(F + 1)) u_round_b (.val_i(s7_fy1_q), .res_o(s8_rb));

  function automatic logic signed [C-1:0] sat_c(input logic signed [RW-1:0] v);
    if (v > SAT_HI)      return C'(SAT_HI);
    else if (v < SAT_LO) return C'(SAT_LO);
    else                 return C'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (stage_en[7]) begin
      s8_l_q <= sat_c(s8_rl);
      s8_t_q <= sat_c(s8_rt);
      s8_r_q <= sat_c(s8_rr);
      s8_b_q <= sat_c(s8_rb);
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: clamp to the image
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] s9_img_w, s9_img_h, s9_r_ext, s9_b_ext;
  logic signed [C-1:0]  s9_l_q, s9_t_q;
  logic signed [CW-1:0] s9_r_q, s9_b_q;

  assign s9_img_w = CW'($signed({1'b0, img_w_q}));
  assign s9_img_h = CW'($signed({1'b0, img_h_q}));
  assign s9_r_ext = CW'(s8_r_q);
  assign s9_b_ext = CW'(s8_b_q);

  always_ff @(posedge clk_i) begin
    if (stage_en[8]) begin
      s9_l_q <= s8_l_q[C-1] ? '0 : s8_l_q;
      s9_t_q <= s8_t_q[C-1] ? '0 : s8_t_q;
      s9_r_q <= (s9_r_ext >= s9_img_w) ? s9_img_w - CW'(1) : s9_r_ext;
      s9_b_q <= (s9_b_ext >= s9_img_h) ? s9_img_h - CW'(1) : s9_b_ext;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: output register with refined width and height
  // --------------------------------------------------------------------------
  logic signed [C-1:0] o_l_q, o_t_q, o_r_q, o_b_q;
  logic signed [C:0]   o_w_q, o_h_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[9]) begin
      o_l_q <= s9_l_q;
      o_t_q <= s9_t_q;
      o_r_q <= C'(s9_r_q);
      o_b_q <= C'(s9_b_q);
      o_w_q <= (C + 1)'(s9_r_q - CW'(s9_l_q));
      o_h_q <= (C + 1)'(s9_b_q - CW'(s9_t_q));
    end
  end

  assign out_ch.valid      = valid_q[NS-1];
  assign out_ch.out_left   = o_l_q;
  assign out_ch.out_top    = o_t_q;
  assign out_ch.out_right  = o_r_q;
  assign out_ch.out_bottom = o_b_q;
  assign out_ch.out_width  = o_w_q;
  assign out_ch.out_height = o_h_q;

endmodule

/* hw/rtl/brr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_checker
// Port-level checks on the box regression refine block: output beat hold,
// clamped corners and the count of boxes in flight.
// ----------------------------------------------------------------------------
module brr_checker #(
  parameter int COORD_BITS = brr_pkg::COORD_BITS_DEF,
  parameter int DEPTH      = brr_pkg::NUM_STAGES
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] out_left_i,
  input logic [COORD_BITS-1:0] out_top_i
);
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] flight_q;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;

  // boxes accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // no result without a box behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> flight_q != '0)
    else $error("result beat with no box in flight");

  // the pipe never holds more boxes than it has stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= CNT_W'(DEPTH))
    else $error("more boxes in flight than pipeline stages");

  // left and top edges are clamped to zero
  a_left_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_left_i[COORD_BITS-1])
    else $error("negative left edge");

  a_top_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_top_i[COORD_BITS-1])
    else $error("negative top edge");

endmodule

bind box_regression_refine brr_checker #(
  .COORD_BITS (COORD_BITS),
  .DEPTH      (brr_pkg::NUM_STAGES)
) u_brr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_left_i  (out_ch.out_left),
  .out_top_i   (out_ch.out_top)
);

/* dv/tb_box_regression_refine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_regression_refine
// Self-checking bench for the box regression refine block. Candidate boxes
// go in over a valid/ready channel, and a fixed-point model in the bench
// predicts each refined box. Every result beat is compared field by field
// with the oldest prediction. The run walks through several image sizes,
// square and plain modes and side scales, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_box_regression_refine;
  import brr_pkg::*;

  localparam int CW        = COORD_BITS_DEF;
  localparam int FW        = FRAC_BITS_DEF;
  localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;
  localparam int PHASES    = 8;
  localparam int PER_PHASE = 165;
  localparam int LONG_HOLD = 80;

  typedef struct {
    logic signed [CW-1:0]        left, top, right, bottom, width, height;
    logic signed [OFFS_BITS-1:0] off_left, off_top, off_right, off_bottom;
  } box_in_t;

  typedef struct {
    logic signed [CW-1:0] left, top, right, bottom;
    logic signed [CW:0]   width, height;
  } box_out_t;

  // register copy, box predictor and store of refined boxes still to come
  class refined_box_board;
    int       img_w, img_h, scale;
    bit       square;
    box_out_t expected_boxes[$];
    int       mismatches, checked;

    function new();
      img_w      = int'(IMAGE_WIDTH_RST);
      img_h      = int'(IMAGE_HEIGHT_RST);
      square     = SQUARE_MODE_RST;
      scale      = int'(SIDE_SCALE_RST);
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  img_w  = int'(val[DIM_BITS-1:0]);
        CFG_IMAGE_HEIGHT: img_h  = int'(val[DIM_BITS-1:0]);
        CFG_SQUARE_MODE:  square = val[0];
        CFG_SIDE_SCALE:   scale  = int'(val[SCALE_BITS-1:0]);
        default: ;
      endcase
    endfunction

    // v / 2^k, halves away from zero
    static function longint round_away(longint v, int k);
      longint half;
      half = longint'(1) << (k - 1);
      if (v >= 0) return (v + half) >>> k;
      return -((half - v) >>> k);
    endfunction

    static function longint sat_coord(longint v);
      if (v > C_MAX) return C_MAX;
      if (v < C_MIN) return C_MIN;
      return v;
    endfunction

    function box_out_t refine_box(box_in_t b);
      longint one, x0, y0, x1, y1, dx0, dy0, dx1, dy1;
      longint w, h, side, hside, l, t, r, bt;
      box_out_t res;
      one = longint'(1) << FW;
      x0  = longint'(b.left)   * one + longint'(b.off_left)   * longint'(b.width);
      y0  = longint'(b.top)    * one + longint'(b.off_top)    * longint'(b.height);
      x1  = longint'(b.right)  * one + longint'(b.off_right)  * longint'(b.width);
      y1  = longint'(b.bottom) * one + longint'(b.off_bottom) * longint'(b.height);
      // doubled, so the centring halves stay exact
      dx0 = 2 * x0;
      dy0 = 2 * y0;
      dx1 = 2 * x1;
      dy1 = 2 * y1;
      if (square) begin
        w     = x1 - x0 + one;
        h     = y1 - y0 + one;
        side  = (h > w) ? h : w;
        hside = round_away(side * longint'(scale), SCALE_FRAC);
        dx0   = 2 * x0 + w - side;
        dy0   = 2 * y0 + h - hside;
        dx1   = dx0 + 2 * side - 2 * one;
        dy1   = dy0 + 2 * hside - 2 * one;
      end
      l  = sat_coord(round_away(dx0, FW + 1));
      t  = sat_coord(round_away(dy0, FW + 1));
      r  = sat_coord(round_away(dx1, FW + 1));
      bt = sat_coord(round_away(dy1, FW + 1));
      // image clamps; the far edges only from above
      if (l < 0) l = 0;
      if (t < 0) t = 0;
      if (r >= img_w) r = img_w - 1;
      if (bt >= img_h) bt = img_h - 1;
      res.left   = CW'(l);
      res.top    = CW'(t);
      res.right  = CW'(r);
      res.bottom = CW'(bt);
      res.width  = (CW + 1)'(r - l);
      res.height = (CW + 1)'(bt - t);
      return res;
    endfunction

    function void note_box(box_in_t b);
      expected_boxes.push_back(refine_box(b));
    endfunction

    function void check_box(box_out_t got);
      box_out_t want;
      longint   w_v[6], g_v[6];
      string    names[6];
      names = '{"left", "top", "right", "bottom", "width", "height"};
      checked++;
      if (expected_boxes.size() == 0) begin
        $display("%0t ns: refined box beat with nothing expected, left %0d top %0d",
                 $time, got.left, got.top);
        mismatches++;
        return;
      end
      want = expected_boxes.pop_front();
      w_v = '{want.left, want.top, want.right, want.bottom, want.width, want.height};
      g_v = '{got.left, got.top, got.right, got.bottom, got.width, got.height};
      for (int i = 0; i < 6; i++) begin
        if (w_v[i] != g_v[i]) begin
          $display("%0t ns: out_%s expected %0d actual %0d", $time, names[i], w_v[i], g_v[i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct = 31;
  int   recv_idle_pct = 61;
  bit   long_hold_req = 1'b0;
  int   boxes_sent    = 0;

  refined_box_board board = new();

  brr_in_if  #(.COORD_BITS(CW)) in_ch ();
  brr_out_if #(.COORD_BITS(CW)) out_ch ();
  brr_cfg_if                    cfg_ch ();

  box_regression_refine #(
    .COORD_BITS(CW),
    .FRAC_BITS (FW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit, far above the slowest clean run
  initial begin
    #2_400_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random ready, plus one long hold on request
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result beats are checked at the edge that takes them
  always @(posedge clk_i) begin
    box_out_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.left   = out_ch.out_left;
      got.top    = out_ch.out_top;
      got.right  = out_ch.out_right;
      got.bottom = out_ch.out_bottom;
      got.width  = out_ch.out_width;
      got.height = out_ch.out_height;
      board.check_box(got);
    end
  end

  function automatic box_in_t mk_box(int l, int t, int r, int bt, int w, int h,
                                     int ol, int ot, int orr, int ob);
    box_in_t b;
    b.left       = CW'(l);
    b.top        = CW'(t);
    b.right      = CW'(r);
    b.bottom     = CW'(bt);
    b.width      = CW'(w);
    b.height     = CW'(h);
    b.off_left   = OFFS_BITS'(ol);
    b.off_top    = OFFS_BITS'(ot);
    b.off_right  = OFFS_BITS'(orr);
    b.off_bottom = OFFS_BITS'(ob);
    return b;
  endfunction

  // mostly plausible detector boxes near the image, the rest raw bits
  function automatic box_in_t make_box(int img_w, int img_h);
    box_in_t b;
    int x, y, w, h, lim;
    if ($urandom_range(99) < 25) begin
      b.left       = CW'($urandom);
      b.top        = CW'($urandom);
      b.right      = CW'($urandom);
      b.bottom     = CW'($urandom);
      b.width      = CW'($urandom);
      b.height     = CW'($urandom);
      b.off_left   = OFFS_BITS'($urandom);
      b.off_top    = OFFS_BITS'($urandom);
      b.off_right  = OFFS_BITS'($urandom);
      b.off_bottom = OFFS_BITS'($urandom);
    end else begin
      lim = ($urandom_range(9) == 0) ? 4000 : 300;
      w   = $urandom_range(lim, 1);
      h   = $urandom_range(lim, 1);
      x   = int'($urandom_range(img_w + 40, 0)) - 20;
      y   = int'($urandom_range(img_h + 40, 0)) - 20;
      b   = mk_box(x, y, x + w - 1, y + h - 1, w, h,
                   int'($urandom_range(12000, 0)) - 6000,
                   int'($urandom_range(12000, 0)) - 6000,
                   int'($urandom_range(12000, 0)) - 6000,
                   int'($urandom_range(12000, 0)) - 6000);
    end
    return b;
  endfunction

  // entered and left at a falling edge; valid stays up after the beat
  task automatic send_box(input box_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.box_left      <= b.left;
    in_ch.box_top       <= b.top;
    in_ch.box_right     <= b.right;
    in_ch.box_bottom    <= b.bottom;
    in_ch.box_width     <= b.width;
    in_ch.box_height    <= b.height;
    in_ch.offset_left   <= b.off_left;
    in_ch.offset_top    <= b.off_top;
    in_ch.offset_right  <= b.off_right;
    in_ch.offset_bottom <= b.off_bottom;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_box(b);
    boxes_sent++;
    @(negedge clk_i);
  endtask

  // stop offering, wait for every refined box, then let the pipe settle
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    while (board.expected_boxes.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // writes all four registers, one beat each
  task automatic write_settings(input int w, input int h, input int sq, input int sc);
    logic [CFG_IDX_BITS-1:0] idxs[4];
    logic [CFG_DAT_BITS-1:0] vals[4];
    idxs = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_SQUARE_MODE, CFG_SIDE_SCALE};
    vals = '{CFG_DAT_BITS'(w), CFG_DAT_BITS'(h), CFG_DAT_BITS'(sq), CFG_DAT_BITS'(sc)};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr  <= idxs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
      board.set_reg(idxs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    box_in_t directed[$];
    // -1 picks a random setting
    int set_w[PHASES]  = '{640, 4096, 1, 0, 1920, -1, 4096, -1};
    int set_h[PHASES]  = '{480, 4096, 1, 0, 1080, -1, 1, -1};
    int set_sq[PHASES] = '{1, 1, 0, 1, 0, -1, 1, -1};
    int set_sc[PHASES] = '{4096, 65535, 0, 0, 4096, -1, 2048, -1};
    int w, h, sq, sc;

    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.box_left      = '0;
    in_ch.box_top       = '0;
    in_ch.box_right     = '0;
    in_ch.box_bottom    = '0;
    in_ch.box_width     = '0;
    in_ch.box_height    = '0;
    in_ch.offset_left   = '0;
    in_ch.offset_top    = '0;
    in_ch.offset_right  = '0;
    in_ch.offset_bottom = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = CFG_IMAGE_WIDTH;
    cfg_ch.data         = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed boxes under the reset settings (square mode)
    directed.push_back(mk_box(10, 20, 109, 219, 100, 200, 0, 0, 0, 0));       // taller
    directed.push_back(mk_box(10, 20, 209, 69, 200, 50, 0, 0, 0, 0));         // wider
    directed.push_back(mk_box(-8192, -8192, -8192, -8192, -8192, -8192,
                              -32768, -32768, -32768, -32768));
    directed.push_back(mk_box(8191, 8191, 8191, 8191, 8191, 8191,
                              32767, 32767, 32767, 32767));
    directed.push_back(mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_box(-8192, 8191, 8191, -8192, 8191, -8192,
                              32767, -32768, -32768, 32767));
    directed.push_back(mk_box(5, 5, 6, 6, 1, 1, 8192, 8192, 8192, 8192));     // +half
    directed.push_back(mk_box(-3, -3, -3, -3, 1, 1, -8192, -8192, -8192, -8192));
    directed.push_back(mk_box(-50, -60, 100, 100, 150, 160, -1000, -1000, 0, 0));
    directed.push_back(mk_box(600, 400, 700, 500, 101, 101, 2000, 2000, 2000, 2000));
    directed.push_back(mk_box(540, 380, 639, 479, 100, 100, 0, 0, 0, 0));     // on the edge
    directed.push_back(mk_box(300, 300, 100, 100, -200, -200, 1000, -1000, 1000, -1000));
    directed.push_back(mk_box(8000, 8000, 8191, 8191, 8191, 8191,
                              32767, 32767, 32767, 32767));                  // saturates
    directed.push_back(mk_box(100, 100, 199, 199, 100, 100, 1, -1, -1, 1));
    directed.push_back(mk_box(50, 50, 50, 50, 0, 0, 16384, 16384, -16384, -16384));
    foreach (directed[i]) send_box(directed[i]);

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      drain(NUM_STAGES + 2);
      w  = (set_w[p] < 0) ? int'($urandom_range(4096, 1)) : set_w[p];
      h  = (set_h[p] < 0) ? int'($urandom_range(4096, 1)) : set_h[p];
      sq = (set_sq[p] < 0) ? int'($urandom_range(1, 0)) : set_sq[p];
      sc = (set_sc[p] < 0) ? int'($urandom_range(65535, 0)) : set_sc[p];
      write_settings(w, h, sq, sc);
      send_idle_pct = (p < 3) ? 31 : (p < 6) ? 61 : 0;
      recv_idle_pct = (p < 3) ? 61 : (p < 6) ? 31 : 0;
      for (int i = 0; i < PER_PHASE; i++) begin
        // long result stall while boxes keep coming: the pipe backs up
        if (p == 1 && i == 40) long_hold_req = 1'b1;
        // sender pause until everything is out
        if (p == 4 && i == 80) drain(0);
        send_box(make_box(board.img_w, board.img_h));
      end
    end

    drain(NUM_STAGES + 5);
    $display("Run covered %0d boxes over %0d register settings, square and plain modes,",
             boxes_sent, PHASES + 1);
    $display("%0d refined boxes checked, %0d field mismatches.",
             board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
